// File: rtl/ssdr_pkg.sv
// Shared constants, codes and types of the screen shadow refresh block.
package ssdr_pkg;

    localparam int ROWS         = 8;
    localparam int COLS         = 30;
    localparam int SEG_LEN      = 15;
    localparam int DEPTH        = ROWS * COLS;
    localparam int AW           = $clog2(DEPTH);
    localparam int SEGS_PER_ROW = (COLS + SEG_LEN - 1) / SEG_LEN;
    localparam int HALF_W       = (SEGS_PER_ROW > 1) ? $clog2(SEGS_PER_ROW) : 1;
    localparam int SROW_W       = $clog2(ROWS + 1);
    localparam int LEN_W        = $clog2(SEG_LEN + 1);
    localparam int COL_W        = $clog2(COLS);

    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] RESEND_FILL = 8'h01;
    localparam logic [7:0] RESET_PAGE  = 8'd6;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_CURSOR = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_RESEND = 3'd3,
        CMD_PAGE   = 3'd4,
        CMD_SCAN   = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAGE,
        ST_SEG,
        ST_CMP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic [7:0]    wr_data;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          clr;
    } mem_req_t;

endpackage

// File: rtl/ssdr_store.sv
// Character store: synchronous RAM with per-entry valid bits and a fill value.
module ssdr_store (
    input  logic                clk,
    input  logic                rst_n,
    input  ssdr_pkg::mem_req_t  req,
    input  logic [7:0]          fill,
    output logic [7:0]          rd_data
);

    logic [7:0]                     store_mem [ssdr_pkg::DEPTH];
    logic [ssdr_pkg::DEPTH-1:0]     valid_reg;
    logic                           rd_valid_reg;
    logic [7:0]                     rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= store_mem[req.rd_addr];
        end
    end

    // An entry that was not written since the last clear reads as the fill value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : fill;

endmodule

// File: rtl/ssdr_ctrl.sv
// Command decoder, scan sequencer and output register of the refresh block.
module ssdr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          command,
    input  logic [3:0]          row_in,
    input  logic [4:0]          col_in,
    input  logic [7:0]          char_in,
    input  logic [7:0]          page_in,
    output ssdr_pkg::mem_req_t  scr_req,
    output ssdr_pkg::mem_req_t  sh_req,
    output logic [7:0]          sh_fill,
    input  logic [7:0]          scr_rd,
    input  logic [7:0]          sh_rd,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [2:0]          seg_row,
    output logic [3:0]          seg_col,
    output logic [7:0]          page_out,
    output logic [7:0]          char_out,
    output logic                last
);

    ssdr_pkg::state_t                   state_reg, state_next;
    logic [3:0]                         cursor_row_reg, cursor_row_next;
    logic [4:0]                         cursor_col_reg, cursor_col_next;
    logic                               changes_pending_reg, changes_pending_next;
    logic                               scan_active_reg, scan_active_next;
    logic                               page_pending_reg, page_pending_next;
    logic [ssdr_pkg::SROW_W-1:0]        scan_row_reg, scan_row_next;
    logic [ssdr_pkg::HALF_W-1:0]        scan_half_reg, scan_half_next;
    logic [7:0]                         wanted_page_reg, wanted_page_next;
    logic [7:0]                         shadow_fill_reg, shadow_fill_next;
    logic [2:0]                         seg_row_reg, seg_row_next;
    logic [ssdr_pkg::COL_W-1:0]         seg_start_reg, seg_start_next;
    logic [ssdr_pkg::AW-1:0]            seg_base_reg, seg_base_next;
    logic [ssdr_pkg::LEN_W-1:0]         seg_len_reg, seg_len_next;
    logic [ssdr_pkg::LEN_W-1:0]         iss_reg, iss_next;
    logic [ssdr_pkg::LEN_W-1:0]         emit_cnt_reg, emit_cnt_next;
    logic                               pend_reg, pend_next;
    logic                               diff_reg, diff_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               kind_reg, kind_next;
    logic [2:0]                         out_row_reg, out_row_next;
    logic [3:0]                         out_col_reg, out_col_next;
    logic [7:0]                         page_out_reg, page_out_next;
    logic [7:0]                         char_out_reg, char_out_next;
    logic                               last_reg, last_next;

    ssdr_pkg::cmd_t                     cmd;
    logic                               in_accept;
    logic                               cur_ok;
    logic [ssdr_pkg::AW-1:0]            cur_addr;
    logic [ssdr_pkg::AW-1:0]            rd_addr;
    logic                               out_free;
    logic                               cmp_issue;
    logic                               cmp_done;
    logic                               neq;
    logic                               em_load;
    logic                               em_issue;
    logic                               em_last;
    logic                               page_load;
    logic                               row_done;

    // Handshake and memory control.
    always_comb
    begin
        cmd       = ssdr_pkg::cmd_t'(command);
        in_stall  = (state_reg != ssdr_pkg::ST_IDLE);
        in_accept = in_valid && !in_stall;
        cur_ok    = (32'(cursor_row_reg) < ssdr_pkg::ROWS) &&
                    (32'(cursor_col_reg) < ssdr_pkg::COLS);
        cur_addr  = ssdr_pkg::AW'(32'(cursor_row_reg) * ssdr_pkg::COLS +
                                  32'(cursor_col_reg));
        rd_addr   = seg_base_reg + ssdr_pkg::AW'(iss_reg);
        out_free  = !out_valid_reg || !out_stall;
        row_done  = (32'(scan_row_reg) >= ssdr_pkg::ROWS);
        neq       = (scr_rd != sh_rd);
        cmp_issue = (state_reg == ssdr_pkg::ST_CMP) && (iss_reg != seg_len_reg);
        cmp_done  = (state_reg == ssdr_pkg::ST_CMP) && (iss_reg == seg_len_reg) && pend_reg;
        em_load   = (state_reg == ssdr_pkg::ST_EMIT) && pend_reg && out_free;
        em_issue  = (state_reg == ssdr_pkg::ST_EMIT) && (iss_reg != seg_len_reg) &&
                    (!pend_reg || em_load);
        em_last   = (emit_cnt_reg == seg_len_reg - ssdr_pkg::LEN_W'(1));
        page_load = (state_reg == ssdr_pkg::ST_PAGE) && out_free;

        scr_req.wr_en   = in_accept && (cmd == ssdr_pkg::CMD_WRITE) && cur_ok;
        scr_req.wr_addr = cur_addr;
        scr_req.wr_data = char_in;
        scr_req.rd_en   = cmp_issue || em_issue;
        scr_req.rd_addr = rd_addr;
        scr_req.clr     = in_accept && (cmd == ssdr_pkg::CMD_CLEAR);

        sh_req.wr_en    = em_load;
        sh_req.wr_addr  = seg_base_reg + ssdr_pkg::AW'(emit_cnt_reg);
        sh_req.wr_data  = scr_rd;
        sh_req.rd_en    = cmp_issue;
        sh_req.rd_addr  = rd_addr;
        sh_req.clr      = in_accept && ((cmd == ssdr_pkg::CMD_RESEND) ||
                          ((cmd == ssdr_pkg::CMD_SCAN) && page_pending_reg));
        sh_fill         = shadow_fill_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssdr_pkg::ST_IDLE:
            begin
                if (in_accept && (cmd == ssdr_pkg::CMD_SCAN))
                begin
                    if (page_pending_reg)
                    begin
                        state_next = ssdr_pkg::ST_PAGE;
                    end
                    else if (scan_active_reg || changes_pending_reg)
                    begin
                        state_next = ssdr_pkg::ST_SEG;
                    end
                end
            end
            ssdr_pkg::ST_PAGE:
            begin
                if (page_load)
                begin
                    state_next = ssdr_pkg::ST_IDLE;
                end
            end
            ssdr_pkg::ST_SEG:
            begin
                state_next = row_done ? ssdr_pkg::ST_IDLE : ssdr_pkg::ST_CMP;
            end
            ssdr_pkg::ST_CMP:
            begin
                if (cmp_done)
                begin
                    state_next = (diff_reg || neq) ? ssdr_pkg::ST_EMIT : ssdr_pkg::ST_SEG;
                end
            end
            ssdr_pkg::ST_EMIT:
            begin
                if (em_load && em_last)
                begin
                    state_next = ssdr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and bookkeeping registers.
    always_comb
    begin
        int start;
        int rem;
        start                = 32'(scan_half_reg) * ssdr_pkg::SEG_LEN;
        rem                  = ssdr_pkg::COLS - start;
        cursor_row_next      = cursor_row_reg;
        cursor_col_next      = cursor_col_reg;
        changes_pending_next = changes_pending_reg;
        scan_active_next     = scan_active_reg;
        page_pending_next    = page_pending_reg;
        scan_row_next        = scan_row_reg;
        scan_half_next       = scan_half_reg;
        wanted_page_next     = wanted_page_reg;
        shadow_fill_next     = shadow_fill_reg;
        seg_row_next         = seg_row_reg;
        seg_start_next       = seg_start_reg;
        seg_base_next        = seg_base_reg;
        seg_len_next         = seg_len_reg;
        iss_next             = iss_reg;
        emit_cnt_next        = emit_cnt_reg;
        pend_next            = pend_reg;
        diff_next            = diff_reg;
        out_valid_next       = out_valid_reg && out_stall;
        kind_next            = kind_reg;
        out_row_next         = out_row_reg;
        out_col_next         = out_col_reg;
        page_out_next        = page_out_reg;
        char_out_next        = char_out_reg;
        last_next            = last_reg;

        if (in_accept)
        begin
            case (cmd)
                ssdr_pkg::CMD_WRITE:
                begin
                    if (cur_ok)
                    begin
                        // The cursor stops at the last column.
                        if (32'(cursor_col_reg) < ssdr_pkg::COLS - 1)
                        begin
                            cursor_col_next = cursor_col_reg + 5'd1;
                        end
                        changes_pending_next = 1'b1;
                    end
                end
                ssdr_pkg::CMD_CURSOR:
                begin
                    cursor_row_next = row_in;
                    cursor_col_next = col_in;
                end
                ssdr_pkg::CMD_CLEAR:
                begin
                    changes_pending_next = 1'b1;
                end
                ssdr_pkg::CMD_RESEND:
                begin
                    shadow_fill_next     = ssdr_pkg::RESEND_FILL;
                    changes_pending_next = 1'b1;
                end
                ssdr_pkg::CMD_PAGE:
                begin
                    wanted_page_next  = page_in;
                    page_pending_next = 1'b1;
                end
                ssdr_pkg::CMD_SCAN:
                begin
                    if (page_pending_reg)
                    begin
                        page_pending_next    = 1'b0;
                        shadow_fill_next     = ssdr_pkg::BLANK_CHAR;
                        changes_pending_next = 1'b1;
                        scan_active_next     = 1'b0;
                    end
                    else if (!scan_active_reg && changes_pending_reg)
                    begin
                        scan_active_next     = 1'b1;
                        changes_pending_next = 1'b0;
                        scan_row_next        = '0;
                        scan_half_next       = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (state_reg == ssdr_pkg::ST_SEG)
        begin
            if (row_done)
            begin
                scan_active_next = 1'b0;
                scan_row_next    = '0;
                scan_half_next   = '0;
            end
            else
            begin
                seg_row_next   = 3'(scan_row_reg);
                seg_start_next = ssdr_pkg::COL_W'(start);
                seg_base_next  = ssdr_pkg::AW'(32'(scan_row_reg) * ssdr_pkg::COLS + start);
                seg_len_next   = ssdr_pkg::LEN_W'((rem > ssdr_pkg::SEG_LEN) ?
                                                  ssdr_pkg::SEG_LEN : rem);
                if (32'(scan_half_reg) == ssdr_pkg::SEGS_PER_ROW - 1)
                begin
                    scan_half_next = '0;
                    scan_row_next  = scan_row_reg + ssdr_pkg::SROW_W'(1);
                end
                else
                begin
                    scan_half_next = scan_half_reg + ssdr_pkg::HALF_W'(1);
                end
                iss_next  = '0;
                pend_next = 1'b0;
                diff_next = 1'b0;
            end
        end

        if (state_reg == ssdr_pkg::ST_CMP)
        begin
            if (cmp_issue)
            begin
                iss_next = iss_reg + ssdr_pkg::LEN_W'(1);
            end
            pend_next = cmp_issue;
            if (pend_reg)
            begin
                diff_next = diff_reg || neq;
            end
            if (cmp_done)
            begin
                iss_next      = '0;
                emit_cnt_next = '0;
                pend_next     = 1'b0;
            end
        end

        if (state_reg == ssdr_pkg::ST_EMIT)
        begin
            if (em_issue)
            begin
                iss_next  = iss_reg + ssdr_pkg::LEN_W'(1);
                pend_next = 1'b1;
            end
            else if (em_load)
            begin
                pend_next = 1'b0;
            end
            if (em_load)
            begin
                emit_cnt_next  = emit_cnt_reg + ssdr_pkg::LEN_W'(1);
                out_valid_next = 1'b1;
                kind_next      = 1'b1;
                out_row_next   = seg_row_reg;
                out_col_next   = 4'(seg_start_reg);
                page_out_next  = 8'd0;
                char_out_next  = scr_rd;
                last_next      = em_last;
            end
        end

        if (page_load)
        begin
            out_valid_next = 1'b1;
            kind_next      = 1'b0;
            out_row_next   = 3'd0;
            out_col_next   = 4'd0;
            page_out_next  = wanted_page_reg;
            char_out_next  = 8'd0;
            last_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ssdr_pkg::ST_IDLE;
            cursor_row_reg      <= 4'd0;
            cursor_col_reg      <= 5'd0;
            changes_pending_reg <= 1'b1;
            scan_active_reg     <= 1'b0;
            page_pending_reg    <= 1'b1;
            scan_row_reg        <= '0;
            scan_half_reg       <= '0;
            wanted_page_reg     <= ssdr_pkg::RESET_PAGE;
            shadow_fill_reg     <= ssdr_pkg::BLANK_CHAR;
            iss_reg             <= '0;
            emit_cnt_reg        <= '0;
            pend_reg            <= 1'b0;
            diff_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            cursor_row_reg      <= cursor_row_next;
            cursor_col_reg      <= cursor_col_next;
            changes_pending_reg <= changes_pending_next;
            scan_active_reg     <= scan_active_next;
            page_pending_reg    <= page_pending_next;
            scan_row_reg        <= scan_row_next;
            scan_half_reg       <= scan_half_next;
            wanted_page_reg     <= wanted_page_next;
            shadow_fill_reg     <= shadow_fill_next;
            iss_reg             <= iss_next;
            emit_cnt_reg        <= emit_cnt_next;
            pend_reg            <= pend_next;
            diff_reg            <= diff_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_row_reg   <= seg_row_next;
        seg_start_reg <= seg_start_next;
        seg_base_reg  <= seg_base_next;
        seg_len_reg   <= seg_len_next;
        kind_reg      <= kind_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        page_out_reg  <= page_out_next;
        char_out_reg  <= char_out_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign seg_row   = out_row_reg;
    assign seg_col   = out_col_reg;
    assign page_out  = page_out_reg;
    assign char_out  = char_out_reg;
    assign last      = last_reg;

endmodule

// File: rtl/screen_shadow_diff_refresh_top.sv
// Top level of the screen buffer with shadow-diff refresh for a text terminal.
//
// The input channel carries one command word per handshake (in_valid high, in_stall
// low at a rising edge). Cursor, write, clear, resend and page commands leave the
// block idle and ready for the next word. A scan step holds in_stall high until its work is done.
// The output channel carries one result word per handshake: either a single page
// select word, or the characters of one changed half-row, with last on the final one.
// A scan step that sends a page select passes through the page state and finishes
// as the page select word enters the free output register. Otherwise each half-row
// it checks takes a setup step, one read per character through the registered RAM
// ports, and a final compare; a step covers at most one pass over the eight rows.
// The changed half-row then streams at one word per cycle while the output does not
// stall, limited by the screen RAM read port, and the block returns to accepting
// commands as the last word enters the output register.
// A stall on the output holds the output register and pauses the character stream.
// Reset clears the per-entry valid bits of both stores at once, so both read as
// spaces, and leaves a page select to page 6 pending for the first scan step.
module screen_shadow_diff_refresh_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [3:0]  row_in,
    input  logic [4:0]  col_in,
    input  logic [7:0]  char_in,
    input  logic [7:0]  page_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  seg_row,
    output logic [3:0]  seg_col,
    output logic [7:0]  page_out,
    output logic [7:0]  char_out,
    output logic        last
);

    // Memory requests from the sequencer to the two character stores.
    ssdr_pkg::mem_req_t scr_req;
    ssdr_pkg::mem_req_t sh_req;
    logic [7:0]         sh_fill;
    logic [7:0]         scr_rd;
    logic [7:0]         sh_rd;

    // The screen store always clears to spaces.
    ssdr_store u_screen (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scr_req),
        .fill    (ssdr_pkg::BLANK_CHAR),
        .rd_data (scr_rd)
    );

    // The shadow store clears to spaces on a page change and to a marker byte on
    // a forced resend; the sequencer keeps the current fill byte.
    ssdr_store u_shadow (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sh_req),
        .fill    (sh_fill),
        .rd_data (sh_rd)
    );

    ssdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .row_in    (row_in),
        .col_in    (col_in),
        .char_in   (char_in),
        .page_in   (page_in),
        .scr_req   (scr_req),
        .sh_req    (sh_req),
        .sh_fill   (sh_fill),
        .scr_rd    (scr_rd),
        .sh_rd     (sh_rd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .seg_row   (seg_row),
        .seg_col   (seg_col),
        .page_out  (page_out),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

// File: sim/screen_shadow_diff_refresh_top_tb.sv
// Self-checking testbench for the screen shadow-diff refresh block.
module screen_shadow_diff_refresh_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Command codes that the block leaves unused; they must do nothing.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // Values of the kind field of a result word.
    localparam logic KIND_PAGE = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam int RESET_CYCLES = 11;
    // This covers the longest silent scan step, a full pass over the screen, with some margin.
    localparam int SETTLE_CYCLES = 400;
    // The receiver's long hold-off, long enough to back the block up.
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_CYCLES = 800000;

    // One command word as the sender offers it.
    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] row;
        logic [4:0] col;
        logic [7:0] ch;
        logic [7:0] page;
    } cmd_word_t;

    // One result word as the terminal side receives it.
    typedef struct packed {
        logic       kind;
        logic [2:0] row;
        logic [3:0] col;
        logic [7:0] page;
        logic [7:0] ch;
        logic       last;
    } term_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] command = '0;
    logic [3:0] row_in = '0;
    logic [4:0] col_in = '0;
    logic [7:0] char_in = '0;
    logic [7:0] page_in = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [2:0] seg_row;
    logic [3:0] seg_col;
    logic [7:0] page_out;
    logic [7:0] char_out;
    logic       last;

    screen_shadow_diff_refresh_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .row_in   (row_in),
        .col_in   (col_in),
        .char_in  (char_in),
        .page_in  (page_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .seg_row  (seg_row),
        .seg_col  (seg_col),
        .page_out (page_out),
        .char_out (char_out),
        .last     (last)
    );

    // Period of 4 ns: two ns high, two ns low.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Command words waiting to be offered, and result words the terminal
    // should see next, oldest first.
    cmd_word_t  pending_cmds[$];
    term_word_t updates_due[$];

    int  err_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  cmd_taken = 1'b0;
    bit  rx_hold = 1'b0;
    event hold_go;

    // The testbench's own copy of the block state: the screen image, the
    // image the terminal is believed to show, the cursor and the scan state.
    logic [7:0] screen_img [ssdr_pkg::DEPTH];
    logic [7:0] shadow_img [ssdr_pkg::DEPTH];
    logic [4:0] cur_col;
    logic [3:0] cur_row;
    bit         dirty;
    bit         scanning;
    int unsigned scan_r;
    int unsigned scan_h;
    logic [7:0] page_want;
    bit         page_due;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    task automatic reset_model();
        for (int i = 0; i < ssdr_pkg::DEPTH; i++)
        begin
            screen_img[i] = ssdr_pkg::BLANK_CHAR;
            shadow_img[i] = ssdr_pkg::BLANK_CHAR;
        end
        cur_col = '0;
        cur_row = '0;
        dirty = 1'b1;
        scanning = 1'b0;
        scan_r = 0;
        scan_h = 0;
        page_want = ssdr_pkg::RESET_PAGE;
        page_due = 1'b1;
    endtask

    // Applies one accepted command word to the model and queues the result
    // words the terminal should receive because of it.
    task automatic predict_terminal_update(input cmd_word_t w);
        int unsigned start;
        int unsigned len;
        int unsigned base;
        int unsigned seg_r;
        bit differ;
        bit found;
        case (w.cmd)
            ssdr_pkg::CMD_WRITE:
            begin
                // Writes with the cursor off the screen are dropped entirely.
                if (cur_row < ssdr_pkg::ROWS && cur_col < ssdr_pkg::COLS)
                begin
                    screen_img[cur_row * ssdr_pkg::COLS + cur_col] = w.ch;
                    // The cursor sticks at the last column.
                    if (cur_col < ssdr_pkg::COLS - 1)
                        cur_col = cur_col + 1'b1;
                    dirty = 1'b1;
                end
            end
            ssdr_pkg::CMD_CURSOR:
            begin
                cur_row = w.row;
                cur_col = w.col;
            end
            ssdr_pkg::CMD_CLEAR:
            begin
                for (int i = 0; i < ssdr_pkg::DEPTH; i++)
                    screen_img[i] = ssdr_pkg::BLANK_CHAR;
                dirty = 1'b1;
            end
            ssdr_pkg::CMD_RESEND:
            begin
                // A fill no screen holds normally, so nearly every half-row differs.
                for (int i = 0; i < ssdr_pkg::DEPTH; i++)
                    shadow_img[i] = ssdr_pkg::RESEND_FILL;
                dirty = 1'b1;
            end
            ssdr_pkg::CMD_PAGE:
            begin
                page_want = w.page;
                page_due = 1'b1;
            end
            ssdr_pkg::CMD_SCAN:
            begin
                if (page_due)
                begin
                    // A page change wins: one page select word, blank shadow,
                    // and any scan in progress is dropped.
                    page_due = 1'b0;
                    for (int i = 0; i < ssdr_pkg::DEPTH; i++)
                        shadow_img[i] = ssdr_pkg::BLANK_CHAR;
                    dirty = 1'b1;
                    scanning = 1'b0;
                    updates_due.push_back('{KIND_PAGE, 3'd0, 4'd0, page_want, 8'h00, 1'b1});
                end
                else
                begin
                    if (dirty && !scanning)
                    begin
                        scanning = 1'b1;
                        dirty = 1'b0;
                        scan_r = 0;
                        scan_h = 0;
                    end
                    if (scanning)
                    begin
                        found = 1'b0;
                        while (scan_r < ssdr_pkg::ROWS && !found)
                        begin
                            start = scan_h * ssdr_pkg::SEG_LEN;
                            len = ssdr_pkg::COLS - start;
                            if (len > ssdr_pkg::SEG_LEN)
                                len = ssdr_pkg::SEG_LEN;
                            seg_r = scan_r;
                            base = seg_r * ssdr_pkg::COLS + start;
                            scan_h++;
                            if (scan_h >= ssdr_pkg::SEGS_PER_ROW)
                            begin
                                scan_h = 0;
                                scan_r++;
                            end
                            differ = 1'b0;
                            for (int i = 0; i < len; i++)
                                if (screen_img[base + i] != shadow_img[base + i])
                                    differ = 1'b1;
                            if (differ)
                            begin
                                found = 1'b1;
                                for (int i = 0; i < len; i++)
                                begin
                                    shadow_img[base + i] = screen_img[base + i];
                                    updates_due.push_back('{KIND_TEXT, 3'(seg_r), 4'(start),
                                        8'h00, screen_img[base + i], (i + 1 == len)});
                                end
                            end
                        end
                        // Nothing left that differs: the scan ends silently.
                        if (!found)
                        begin
                            scanning = 1'b0;
                            scan_r = 0;
                            scan_h = 0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic cmd_word_t random_word(input logic [2:0] code);
        cmd_word_t w;
        w.cmd = code;
        w.row = 4'($urandom_range(15));
        w.col = 5'($urandom_range(31));
        w.ch = 8'($urandom_range(255));
        w.page = 8'($urandom_range(255));
        return w;
    endfunction

    task automatic queue_word(input logic [2:0] code, input logic [3:0] r, input logic [4:0] c,
                              input logic [7:0] ch, input logic [7:0] pg);
        pending_cmds.push_back('{code, r, c, ch, pg});
    endtask

    // Most traffic is a cursor placement, a run of characters and a few scan
    // steps, which is what walks the scan deep into the screen. The rest is
    // bare scans, page changes, clears, resends and plain noise.
    task automatic queue_random_traffic(input int target);
        int issued;
        int pick;
        int n;
        cmd_word_t w;
        issued = 0;
        while (issued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                w = random_word(ssdr_pkg::CMD_CURSOR);
                if ($urandom_range(9) != 0)
                begin
                    w.row = 4'($urandom_range(ssdr_pkg::ROWS - 1));
                    w.col = 5'($urandom_range(ssdr_pkg::COLS - 1));
                end
                pending_cmds.push_back(w);
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++)
                begin
                    w = random_word(ssdr_pkg::CMD_WRITE);
                    // Some spaces, so a write does not always change the screen.
                    if ($urandom_range(4) == 0)
                        w.ch = ssdr_pkg::BLANK_CHAR;
                    pending_cmds.push_back(w);
                end
                issued += n + 1;
                n = $urandom_range(4, 1);
                repeat (n) pending_cmds.push_back(random_word(ssdr_pkg::CMD_SCAN));
                issued += n;
            end
            else if (pick < 70)
            begin
                n = $urandom_range(6, 2);
                repeat (n) pending_cmds.push_back(random_word(ssdr_pkg::CMD_SCAN));
                issued += n;
            end
            else if (pick < 78)
            begin
                pending_cmds.push_back(random_word(ssdr_pkg::CMD_PAGE));
                pending_cmds.push_back(random_word(ssdr_pkg::CMD_SCAN));
                issued += 2;
            end
            else if (pick < 83)
            begin
                pending_cmds.push_back(random_word(ssdr_pkg::CMD_CLEAR));
                issued++;
            end
            else if (pick < 88)
            begin
                pending_cmds.push_back(random_word(ssdr_pkg::CMD_RESEND));
                issued++;
            end
            else
            begin
                w = random_word(3'($urandom_range(7)));
                pending_cmds.push_back(w);
                // Spare codes are ignored by the block and are not counted.
                if (w.cmd != CMD_SPARE_6 && w.cmd != CMD_SPARE_7)
                    issued++;
            end
        end
    endtask

    // Returns once every queued word has been taken and every expected
    // result word has arrived.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || in_valid)
            @(posedge clk);
        while (updates_due.size() != 0)
            @(posedge clk);
    endtask

    // Sender: a word stays on the bus until taken; only then may the next
    // one be offered or a gap be inserted. Inputs change on the falling edge.
    always @(negedge clk)
    begin : cmd_driver
        cmd_word_t w;
        if (!in_valid || cmd_taken)
        begin
            if (rst_n && pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_cmds.pop_front();
                in_valid <= 1'b1;
                command <= w.cmd;
                row_in <= w.row;
                col_in <= w.col;
                char_in <= w.ch;
                page_in <= w.page;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a forced stall while the long hold-off runs.
    always @(negedge clk)
    begin
        out_stall <= rx_hold || ($urandom_range(99) < recv_idle_pct);
    end

    // The long hold-off counts its own cycles so the sender keeps going.
    always
    begin
        @(hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    // Both handshakes are sampled on the rising edge. An accepted command
    // updates the model first, then an accepted result word is checked
    // against the oldest one still due.
    always @(posedge clk)
    begin : monitor
        term_word_t want;
        if (!rst_n)
        begin
            cmd_taken = 1'b0;
        end
        else
        begin
            cmd_taken = in_valid && !in_stall;
            if (cmd_taken)
                predict_terminal_update('{command, row_in, col_in, char_in, page_in});
            if (out_valid && !out_stall)
            begin
                if (updates_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word kind=%0d row=%0d col=%0d ch=%02h",
                        kind, seg_row, seg_col, char_out));
                end
                else
                begin
                    want = updates_due.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                    if (seg_row !== want.row)
                        report_mismatch($sformatf("seg_row %0d, want %0d", seg_row, want.row));
                    if (seg_col !== want.col)
                        report_mismatch($sformatf("seg_col %0d, want %0d", seg_col, want.col));
                    if (page_out !== want.page)
                        report_mismatch($sformatf("page_out %0d, want %0d", page_out, want.page));
                    if (char_out !== want.ch)
                        report_mismatch($sformatf("char_out %02h, want %02h", char_out, want.ch));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0d, want %0d", last, want.last));
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed opening, run with light sender gaps and a receiver that stalls most cycles.
        send_idle_pct = 17;
        recv_idle_pct = 87;
        // First scan settles the page select left pending by reset; the next
        // one starts a scan that finds nothing; the third has nothing to do.
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_SCAN, 4'd15, 5'd31, 8'hFF, 8'hFF);
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        // Character extremes at the top left corner.
        queue_word(ssdr_pkg::CMD_CURSOR, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd15, 5'd31, 8'hFF, 8'hFF);
        // Cursor at the right edge: the third write overwrites column 29.
        queue_word(ssdr_pkg::CMD_CURSOR, 4'd7, 5'd28, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd0, 5'd0, 8'h41, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd0, 5'd0, 8'h42, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd0, 5'd0, 8'h43, 8'h00);
        // Writes with the cursor below the last row or past the last column.
        queue_word(ssdr_pkg::CMD_CURSOR, 4'd8, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd0, 5'd0, 8'h58, 8'h00);
        queue_word(ssdr_pkg::CMD_CURSOR, 4'd3, 5'd30, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_WRITE, 4'd0, 5'd0, 8'h59, 8'h00);
        queue_word(CMD_SPARE_6, 4'd15, 5'd31, 8'hFF, 8'hFF);
        queue_word(CMD_SPARE_7, 4'd0, 5'd0, 8'h00, 8'h00);
        // Scan picks up row 0 left half, then row 7 right half, then ends.
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        // Forced resend, then a page change that preempts the scan.
        queue_word(ssdr_pkg::CMD_RESEND, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_PAGE, 4'd0, 5'd0, 8'h00, 8'hFF);
        queue_word(ssdr_pkg::CMD_SCAN, 4'd0, 5'd0, 8'h00, 8'h00);
        queue_word(ssdr_pkg::CMD_CLEAR, 4'd0, 5'd0, 8'h00, 8'h00);
        wait_drained();

        // Phase one: sender gaps now and then, receiver stalls most cycles.
        queue_random_traffic(160);
        wait_drained();

        // Phase two: the other way round.
        send_idle_pct = 87;
        recv_idle_pct = 17;
        queue_random_traffic(160);
        wait_drained();

        // Phase three: no idling at all, with a long receiver hold-off at the
        // start so the output backs up and the block stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_traffic(160);
        -> hold_go;
        wait_drained();

        // Let any silent scan still in flight finish before judging.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (updates_due.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", updates_due.size()));
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
